[hw/rtl/implicit_list_heap_allocator_defines.svh]
// Assertion macros used by the allocator top level.
// The checks compile away when SYNTH is defined.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define ILHA_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ilha check failed");
`define ILHA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ilha check failed");
`else
`define ILHA_ASSERT_SAME(name, clk, rst, ante, cons)
`define ILHA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/ilha_pkg.sv]
`timescale 1ns / 1ps

package ilha_pkg;

  localparam int HEAP_BYTES_DEFAULT = 65536;

  localparam int OPC_W   = 2;
  localparam int REQ_W   = 16;
  localparam int ADDR_W  = 16;
  localparam int CHUNK_W = 17;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

  localparam logic [OPC_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPC_W-1:0] OP_FREE  = 2'd2;

  localparam int MIN_BLOCK     = 16;
  localparam int FIRST_PAYLOAD = 8;
  localparam int PROLOGUE_END  = 16;

  typedef enum logic [4:0] {
    U_IDLE,
    U_ACCEPT,
    U_PRO_PAD,
    U_PRO_HDR,
    U_PRO_FTR,
    U_PRO_EPI,
    U_FF_INIT,
    U_FF_STEP,
    U_NOFIT,
    U_EXT_GROW,
    U_HDR,
    U_FTR,
    U_EPI,
    U_RD_HDR,
    U_RD_PFT,
    U_MG_PREV,
    U_MG_SELF,
    U_MG_PA,
    U_MG_NA,
    U_FREE_SZ,
    U_PLACE,
    U_SPLIT2,
    U_OK,
    U_INIT_OK
  } uop_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_PRO_PAD,
    S_PRO_HDR,
    S_PRO_FTR,
    S_PRO_EPI,
    S_AL_FF0,
    S_FF_CHK,
    S_FF_STEP,
    S_NOFIT,
    S_EXT_CHK,
    S_EXT_GROW,
    S_EXT_HDR,
    S_EXT_FTR,
    S_EXT_EPI,
    S_MG_RD0,
    S_MG_PREV,
    S_MG_SELF,
    S_MG_PA,
    S_MG_NA,
    S_MG_HDR,
    S_MG_FTR,
    S_PL_RD,
    S_PL_DEC,
    S_PL_HDR,
    S_PL_FTR,
    S_PL_SPLIT,
    S_PL_HDR2,
    S_PL_FTR2,
    S_FR_RD,
    S_FR_SZ,
    S_FR_HDR,
    S_FR_FTR,
    S_FIN_INIT,
    S_FIN_OK,
    S_DONE
  } state_t;

  typedef struct packed {
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic initialised;
    logic req_zero;
    logic ff_in;
    logic ff_zero;
    logic ff_hit;
    logic ext_fits;
    logic merge_skip;
    logic split;
  } status_t;

endpackage

[hw/rtl/implicit_list_heap_allocator.sv]
`timescale 1ns / 1ps
// First-fit heap allocator with boundary tags over an on-chip tag store of
// HEAP_BYTES bytes. Raise start while busy is low to issue init, allocate or
// free; the command transfer is taken at that clock edge. The answer appears
// on address and ok for exactly one cycle, flagged by done, and cannot be held
// off, so the receiver must take it in that cycle. A new command may be issued
// in the cycle that done is shown. Every command works through the
// tag store (one write port, one read port) one access per cycle, so its
// length is set by the number of tag reads and writes it needs. After the
// accepting edge, busy stays high while init lays down the prologue and the
// first chunk, while free rewrites the block's tags and merges it with any
// free neighbor, and while allocate runs the first-fit scan and then places
// the block, splitting it when the rest is large enough, or grows the heap
// first when no block fits and the heap can grow. The answer follows in the
// cycle that busy falls; commands refused outright (before init, a zero
// size, an unknown opcode) answer in the cycle after the accepting edge. The
// chunk size register is written through the cfg channel between commands and
// is rounded up to a multiple of eight, with a floor of sixteen bytes. The tag
// store is not cleared after reset; init lays down every tag the allocator
// later reads.
`include "implicit_list_heap_allocator_defines.svh"

module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ilha_pkg::OPC_W-1:0]    opcode,
  input  logic [ilha_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ilha_pkg::ADDR_W-1:0]   block_address,
  output logic                          done,
  output logic [ilha_pkg::ADDR_W-1:0]   address,
  output logic                          ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ilha_pkg::CHUNK_W-1:0]  chunk_bytes
);

  ilha_pkg::cmd_t    cmd;
  ilha_pkg::status_t status;

  // The register transfer is taken only between commands.
  assign cfg_ready = !busy;

  // The controller sequences one micro-operation per cycle.
  ilha_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath holds the break, the scan pointers and the tag store.
  ilha_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .cfg_we        (cfg_valid && cfg_ready),
    .chunk_bytes   (chunk_bytes),
    .address       (address),
    .ok            (ok)
  );

  // An accepted command either starts work or answers in the next cycle.
  `ILHA_ASSERT_NEXT(a_accept_moves, clk, rst, start && !busy, busy || done)
  // A result is never shown while the block still reports itself busy.
  `ILHA_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy)
  // A result follows either work in progress or a command just accepted.
  `ILHA_ASSERT_SAME(a_done_has_cause, clk, rst, done, $past(busy) || $past(start))

endmodule

[hw/rtl/ilha_ram.sv]
`timescale 1ns / 1ps

module ilha_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ilha_ctrl.sv]
`timescale 1ns / 1ps

module ilha_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ilha_pkg::OPC_W-1:0]     opcode,
  input  ilha_pkg::status_t              status,
  output ilha_pkg::cmd_t                 cmd,
  output logic                           busy,
  output logic                           done
);

  ilha_pkg::state_t state;
  ilha_pkg::state_t state_next;
  logic [ilha_pkg::OPC_W-1:0] op;
  ilha_pkg::state_t after_merge;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilha_pkg::S_IDLE;
      op    <= ilha_pkg::OP_INIT;
    end else begin
      state <= state_next;
      if (start && !busy) begin
        op <= opcode;
      end
    end
  end

  always_comb begin
    case (op)
      ilha_pkg::OP_INIT:  after_merge = ilha_pkg::S_FIN_INIT;
      ilha_pkg::OP_ALLOC: after_merge = ilha_pkg::S_PL_RD;
      default:            after_merge = ilha_pkg::S_FIN_OK;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ilha_pkg::S_IDLE, ilha_pkg::S_DONE: begin
        if (start) begin
          case (opcode)
            ilha_pkg::OP_INIT: state_next = ilha_pkg::S_PRO_PAD;
            ilha_pkg::OP_ALLOC: begin
              state_next = (status.initialised && !status.req_zero) ?
                           ilha_pkg::S_AL_FF0 : ilha_pkg::S_DONE;
            end
            ilha_pkg::OP_FREE: begin
              state_next = status.initialised ? ilha_pkg::S_FR_RD : ilha_pkg::S_DONE;
            end
            default: state_next = ilha_pkg::S_DONE;
          endcase
        end else begin
          state_next = ilha_pkg::S_IDLE;
        end
      end
      ilha_pkg::S_PRO_PAD:  state_next = ilha_pkg::S_PRO_HDR;
      ilha_pkg::S_PRO_HDR:  state_next = ilha_pkg::S_PRO_FTR;
      ilha_pkg::S_PRO_FTR:  state_next = ilha_pkg::S_PRO_EPI;
      ilha_pkg::S_PRO_EPI:  state_next = ilha_pkg::S_EXT_CHK;
      ilha_pkg::S_AL_FF0:   state_next = ilha_pkg::S_FF_CHK;
      ilha_pkg::S_FF_CHK: begin
        state_next = status.ff_in ? ilha_pkg::S_FF_STEP : ilha_pkg::S_NOFIT;
      end
      ilha_pkg::S_FF_STEP: begin
        if (status.ff_zero) begin
          state_next = ilha_pkg::S_NOFIT;
        end else if (status.ff_hit) begin
          state_next = ilha_pkg::S_PL_RD;
        end else begin
          state_next = ilha_pkg::S_FF_CHK;
        end
      end
      ilha_pkg::S_NOFIT:    state_next = ilha_pkg::S_EXT_CHK;
      ilha_pkg::S_EXT_CHK: begin
        state_next = status.ext_fits ? ilha_pkg::S_EXT_GROW : ilha_pkg::S_DONE;
      end
      ilha_pkg::S_EXT_GROW: state_next = ilha_pkg::S_EXT_HDR;
      ilha_pkg::S_EXT_HDR:  state_next = ilha_pkg::S_EXT_FTR;
      ilha_pkg::S_EXT_FTR:  state_next = ilha_pkg::S_EXT_EPI;
      ilha_pkg::S_EXT_EPI:  state_next = ilha_pkg::S_MG_RD0;
      ilha_pkg::S_MG_RD0:   state_next = ilha_pkg::S_MG_PREV;
      ilha_pkg::S_MG_PREV:  state_next = ilha_pkg::S_MG_SELF;
      ilha_pkg::S_MG_SELF:  state_next = ilha_pkg::S_MG_PA;
      ilha_pkg::S_MG_PA:    state_next = ilha_pkg::S_MG_NA;
      ilha_pkg::S_MG_NA: begin
        state_next = status.merge_skip ? after_merge : ilha_pkg::S_MG_HDR;
      end
      ilha_pkg::S_MG_HDR:   state_next = ilha_pkg::S_MG_FTR;
      ilha_pkg::S_MG_FTR:   state_next = after_merge;
      ilha_pkg::S_PL_RD:    state_next = ilha_pkg::S_PL_DEC;
      ilha_pkg::S_PL_DEC:   state_next = ilha_pkg::S_PL_HDR;
      ilha_pkg::S_PL_HDR:   state_next = ilha_pkg::S_PL_FTR;
      ilha_pkg::S_PL_FTR: begin
        state_next = status.split ? ilha_pkg::S_PL_SPLIT : ilha_pkg::S_FIN_OK;
      end
      ilha_pkg::S_PL_SPLIT: state_next = ilha_pkg::S_PL_HDR2;
      ilha_pkg::S_PL_HDR2:  state_next = ilha_pkg::S_PL_FTR2;
      ilha_pkg::S_PL_FTR2:  state_next = ilha_pkg::S_FIN_OK;
      ilha_pkg::S_FR_RD:    state_next = ilha_pkg::S_FR_SZ;
      ilha_pkg::S_FR_SZ:    state_next = ilha_pkg::S_FR_HDR;
      ilha_pkg::S_FR_HDR:   state_next = ilha_pkg::S_FR_FTR;
      ilha_pkg::S_FR_FTR:   state_next = ilha_pkg::S_MG_RD0;
      ilha_pkg::S_FIN_INIT: state_next = ilha_pkg::S_DONE;
      ilha_pkg::S_FIN_OK:   state_next = ilha_pkg::S_DONE;
      default:              state_next = ilha_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd.uop = ilha_pkg::U_IDLE;
    case (state)
      ilha_pkg::S_IDLE, ilha_pkg::S_DONE: begin
        cmd.uop = start ? ilha_pkg::U_ACCEPT : ilha_pkg::U_IDLE;
      end
      ilha_pkg::S_PRO_PAD:  cmd.uop = ilha_pkg::U_PRO_PAD;
      ilha_pkg::S_PRO_HDR:  cmd.uop = ilha_pkg::U_PRO_HDR;
      ilha_pkg::S_PRO_FTR:  cmd.uop = ilha_pkg::U_PRO_FTR;
      ilha_pkg::S_PRO_EPI:  cmd.uop = ilha_pkg::U_PRO_EPI;
      ilha_pkg::S_AL_FF0:   cmd.uop = ilha_pkg::U_FF_INIT;
      ilha_pkg::S_FF_CHK: begin
        cmd.uop = status.ff_in ? ilha_pkg::U_RD_HDR : ilha_pkg::U_IDLE;
      end
      ilha_pkg::S_FF_STEP:  cmd.uop = ilha_pkg::U_FF_STEP;
      ilha_pkg::S_NOFIT:    cmd.uop = ilha_pkg::U_NOFIT;
      ilha_pkg::S_EXT_GROW: cmd.uop = ilha_pkg::U_EXT_GROW;
      ilha_pkg::S_EXT_HDR, ilha_pkg::S_MG_HDR, ilha_pkg::S_PL_HDR,
      ilha_pkg::S_PL_HDR2, ilha_pkg::S_FR_HDR: cmd.uop = ilha_pkg::U_HDR;
      ilha_pkg::S_EXT_FTR, ilha_pkg::S_MG_FTR, ilha_pkg::S_PL_FTR,
      ilha_pkg::S_PL_FTR2, ilha_pkg::S_FR_FTR: cmd.uop = ilha_pkg::U_FTR;
      ilha_pkg::S_EXT_EPI:  cmd.uop = ilha_pkg::U_EPI;
      ilha_pkg::S_MG_RD0:   cmd.uop = ilha_pkg::U_RD_PFT;
      ilha_pkg::S_MG_PREV:  cmd.uop = ilha_pkg::U_MG_PREV;
      ilha_pkg::S_MG_SELF:  cmd.uop = ilha_pkg::U_MG_SELF;
      ilha_pkg::S_MG_PA:    cmd.uop = ilha_pkg::U_MG_PA;
      ilha_pkg::S_MG_NA:    cmd.uop = ilha_pkg::U_MG_NA;
      ilha_pkg::S_PL_RD:    cmd.uop = ilha_pkg::U_RD_HDR;
      ilha_pkg::S_PL_DEC:   cmd.uop = ilha_pkg::U_PLACE;
      ilha_pkg::S_PL_SPLIT: cmd.uop = ilha_pkg::U_SPLIT2;
      ilha_pkg::S_FR_RD:    cmd.uop = ilha_pkg::U_RD_HDR;
      ilha_pkg::S_FR_SZ:    cmd.uop = ilha_pkg::U_FREE_SZ;
      ilha_pkg::S_FIN_INIT: cmd.uop = ilha_pkg::U_INIT_OK;
      ilha_pkg::S_FIN_OK:   cmd.uop = ilha_pkg::U_OK;
      default:              cmd.uop = ilha_pkg::U_IDLE;
    endcase
  end

  assign busy = !(state inside {ilha_pkg::S_IDLE, ilha_pkg::S_DONE});
  assign done = (state == ilha_pkg::S_DONE);

endmodule

[hw/rtl/ilha_dp.sv]
`timescale 1ns / 1ps

module ilha_dp #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ilha_pkg::cmd_t                cmd,
  output ilha_pkg::status_t             status,
  input  logic [ilha_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ilha_pkg::ADDR_W-1:0]   block_address,
  input  logic                          cfg_we,
  input  logic [ilha_pkg::CHUNK_W-1:0]  chunk_bytes,
  output logic [ilha_pkg::ADDR_W-1:0]   address,
  output logic                          ok
);

  localparam int HB_W   = $clog2(HEAP_BYTES);
  localparam int WORD_W = HB_W + 1;
  localparam int WORDS  = HEAP_BYTES / 4;
  localparam int IDX_W  = $clog2(WORDS);
  localparam int XW     = ((HB_W > ilha_pkg::ADDR_W) ? HB_W : ilha_pkg::ADDR_W) + 4;

  // Offsets are kept in two's complement so that an address computed below
  // zero falls outside the store, as does anything past the last word.
  function automatic logic in_store(input logic [XW-1:0] a);
    in_store = !a[XW-1] && ((a >> 2) < XW'(WORDS));
  endfunction

  logic [XW-1:0] bp, pp, nn, sz, psz, have, need, ext;
  logic [WORD_W-1:0] brk;
  logic pa, abit, split, initialised, rd_ok;
  logic [ilha_pkg::CHUNK_W-1:0] chunk;

  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] rword;
  logic [XW-1:0] rsize;
  logic ralloc;
  logic [XW-1:0] wa, ra;
  logic [WORD_W-1:0] wd;
  logic we, re;
  logic [XW-1:0] need_in, effc, ext_sel, brk_x, tag_x;
  logic split_c;

  assign rword  = rd_ok ? ram_rdata : '0;
  assign rsize  = XW'({rword[WORD_W-1:3], 3'b000});
  assign ralloc = rword[0];

  assign need_in = XW'((ilha_pkg::REQ_W + 1)'(request_bytes) + 17'd15) & ~XW'(7);
  assign effc    = ((XW'(chunk) + XW'(7)) & ~XW'(7)) < XW'(ilha_pkg::MIN_BLOCK) ?
                   XW'(ilha_pkg::MIN_BLOCK) : ((XW'(chunk) + XW'(7)) & ~XW'(7));
  assign ext_sel = (need > effc) ? need : effc;
  assign brk_x   = XW'(brk);
  assign tag_x   = sz | XW'(abit);
  assign split_c = rsize >= (need + XW'(ilha_pkg::MIN_BLOCK));

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    wd = '0;
    case (cmd.uop)
      ilha_pkg::U_PRO_PAD: begin
        we = 1'b1;
        wa = XW'(0);
        wd = '0;
      end
      ilha_pkg::U_PRO_HDR: begin
        we = 1'b1;
        wa = XW'(4);
        wd = WORD_W'(9);
      end
      ilha_pkg::U_PRO_FTR: begin
        we = 1'b1;
        wa = XW'(8);
        wd = WORD_W'(9);
      end
      ilha_pkg::U_PRO_EPI: begin
        we = 1'b1;
        wa = XW'(12);
        wd = WORD_W'(1);
      end
      ilha_pkg::U_HDR: begin
        we = 1'b1;
        wa = bp - XW'(4);
        wd = tag_x[WORD_W-1:0];
      end
      ilha_pkg::U_FTR: begin
        we = 1'b1;
        wa = bp + sz - XW'(8);
        wd = tag_x[WORD_W-1:0];
      end
      ilha_pkg::U_EPI: begin
        we = 1'b1;
        wa = bp + sz - XW'(4);
        wd = WORD_W'(1);
      end
      ilha_pkg::U_RD_HDR, ilha_pkg::U_MG_PREV: begin
        re = 1'b1;
        ra = bp - XW'(4);
      end
      ilha_pkg::U_RD_PFT: begin
        re = 1'b1;
        ra = bp - XW'(8);
      end
      ilha_pkg::U_MG_SELF: begin
        re = 1'b1;
        ra = pp - XW'(4);
      end
      ilha_pkg::U_MG_PA: begin
        re = 1'b1;
        ra = nn - XW'(4);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ilha_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we && in_store(wa)),
    .waddr (wa[IDX_W+1:2]),
    .wdata (wd),
    .raddr (ra[IDX_W+1:2]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      brk         <= '0;
      initialised <= 1'b0;
      chunk       <= ilha_pkg::CHUNK_RESET;
      ok          <= 1'b0;
      rd_ok       <= 1'b0;
    end else begin
      rd_ok <= re && in_store(ra);
      if (cfg_we) begin
        chunk <= chunk_bytes;
      end
      case (cmd.uop)
        ilha_pkg::U_ACCEPT: ok <= 1'b0;
        ilha_pkg::U_PRO_PAD: begin
          brk         <= WORD_W'(ilha_pkg::PROLOGUE_END);
          initialised <= 1'b0;
        end
        ilha_pkg::U_EXT_GROW: brk <= brk + ext[WORD_W-1:0];
        ilha_pkg::U_OK: ok <= 1'b1;
        ilha_pkg::U_INIT_OK: begin
          ok          <= 1'b1;
          initialised <= 1'b1;
        end
        default: begin
          ok <= ok;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.uop)
      ilha_pkg::U_ACCEPT: begin
        need    <= need_in;
        bp      <= XW'(block_address);
        address <= '0;
      end
      ilha_pkg::U_PRO_EPI: ext <= effc;
      ilha_pkg::U_FF_INIT: bp <= XW'(ilha_pkg::FIRST_PAYLOAD);
      ilha_pkg::U_FF_STEP: begin
        if (!(rsize == '0) && !(!ralloc && need <= rsize)) begin
          bp <= bp + rsize;
        end
      end
      ilha_pkg::U_NOFIT: ext <= ext_sel;
      ilha_pkg::U_EXT_GROW: begin
        bp   <= brk_x;
        sz   <= ext;
        abit <= 1'b0;
      end
      ilha_pkg::U_MG_PREV: pp <= bp - rsize;
      ilha_pkg::U_MG_SELF: begin
        sz <= rsize;
        nn <= bp + rsize;
      end
      ilha_pkg::U_MG_PA: begin
        pa  <= ralloc;
        psz <= rsize;
      end
      ilha_pkg::U_MG_NA: begin
        if (!(pa && ralloc)) begin
          sz   <= sz + (pa ? '0 : psz) + (ralloc ? '0 : rsize);
          bp   <= pa ? bp : pp;
          abit <= 1'b0;
        end
      end
      ilha_pkg::U_FREE_SZ: begin
        sz   <= rsize;
        abit <= 1'b0;
      end
      ilha_pkg::U_PLACE: begin
        have    <= rsize;
        split   <= split_c;
        abit    <= 1'b1;
        sz      <= split_c ? need : rsize;
        address <= bp[ilha_pkg::ADDR_W-1:0];
      end
      ilha_pkg::U_SPLIT2: begin
        bp   <= bp + need;
        sz   <= have - need;
        abit <= 1'b0;
      end
      default: begin
        pa <= pa;
      end
    endcase
  end

  always_comb begin
    status.initialised = initialised;
    status.req_zero    = (request_bytes == '0);
    status.ff_in       = (bp - XW'(4)) < brk_x;
    status.ff_zero     = (rsize == '0);
    status.ff_hit      = !ralloc && (need <= rsize);
    status.ext_fits    = (brk_x + ext) <= XW'(HEAP_BYTES);
    status.merge_skip  = pa && ralloc;
    status.split       = split;
  end

endmodule

[sim/implicit_list_heap_allocator_checker.sv]
`timescale 1ns / 1ps

module implicit_list_heap_allocator_checker #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [ilha_pkg::OPC_W-1:0]    opcode,
  input  logic [ilha_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ilha_pkg::ADDR_W-1:0]   block_address,
  input  logic                          done,
  input  logic [ilha_pkg::ADDR_W-1:0]   address,
  input  logic                          ok,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ilha_pkg::CHUNK_W-1:0]  chunk_bytes,
  output int                            fail_count,
  output int                            answers_owed
);

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam longint unsigned ALLOC_FLAG = 1;

  typedef struct packed {
    logic [ilha_pkg::ADDR_W-1:0] address;
    logic                        ok;
  } answer_t;

  // Shadow copy of the allocator's tag store and registers.
  logic [31:0]                   heap_words [HEAP_WORDS];
  longint unsigned               heap_break;
  logic                          heap_up;
  logic [ilha_pkg::CHUNK_W-1:0]  chunk_reg;
  answer_t                       owed_answers [$];

  function automatic longint unsigned tag_rd(longint unsigned off);
    longint unsigned idx;
    idx = off >> 2;
    if (idx >= HEAP_WORDS) return 0;
    return heap_words[idx];
  endfunction

  function automatic void tag_wr(longint unsigned off, longint unsigned val);
    longint unsigned idx;
    idx = off >> 2;
    if (idx < HEAP_WORDS) heap_words[idx] = val[31:0];
  endfunction

  function automatic longint unsigned size_at(longint unsigned bp);
    return tag_rd(bp - 4) & ~64'h7;
  endfunction

  function automatic longint unsigned used_at(longint unsigned bp);
    return tag_rd(bp - 4) & ALLOC_FLAG;
  endfunction

  function automatic void write_tags(longint unsigned bp, longint unsigned sz,
                                     longint unsigned used);
    tag_wr(bp - 4, sz | used);
    tag_wr(bp + sz - 8, sz | used);
  endfunction

  function automatic longint unsigned coalesce(longint unsigned bp);
    longint unsigned prv, nxt, sz;
    prv = bp - (tag_rd(bp - 8) & ~64'h7);
    nxt = bp + size_at(bp);
    sz = size_at(bp);
    if (used_at(prv) != 0 && used_at(nxt) != 0) return bp;
    if (used_at(prv) != 0) begin
      write_tags(bp, sz + size_at(nxt), 0);
      return bp;
    end
    if (used_at(nxt) != 0) begin
      write_tags(prv, sz + size_at(prv), 0);
      return prv;
    end
    write_tags(prv, sz + size_at(prv) + size_at(nxt), 0);
    return prv;
  endfunction

  function automatic bit grow_heap(longint unsigned bytes, output longint unsigned bp);
    longint unsigned old_brk;
    bp = 0;
    if (heap_break + bytes > HEAP_BYTES) return 0;
    old_brk = heap_break;
    heap_break += bytes;
    write_tags(old_brk, bytes, 0);
    tag_wr(old_brk + bytes - 4, ALLOC_FLAG);
    bp = coalesce(old_brk);
    return 1;
  endfunction

  // Chunk register rounded up to eight bytes with a sixteen byte floor.
  function automatic longint unsigned chunk_eff();
    longint unsigned c;
    c = (longint'(chunk_reg) + 7) & ~64'h7;
    return (c < ilha_pkg::MIN_BLOCK) ? ilha_pkg::MIN_BLOCK : c;
  endfunction

  function automatic bit scan_first_fit(longint unsigned need, output longint unsigned hit);
    longint unsigned bp, sz;
    bp = ilha_pkg::FIRST_PAYLOAD;
    hit = 0;
    while (bp - 4 < heap_break) begin
      sz = size_at(bp);
      if (sz == 0) return 0;
      if (used_at(bp) == 0 && need <= sz) begin
        hit = bp;
        return 1;
      end
      bp += sz;
    end
    return 0;
  endfunction

  function automatic void carve(longint unsigned bp, longint unsigned need);
    longint unsigned have;
    have = size_at(bp);
    if (have >= need + ilha_pkg::MIN_BLOCK) begin
      write_tags(bp, need, ALLOC_FLAG);
      write_tags(bp + need, have - need, 0);
    end else begin
      write_tags(bp, have, ALLOC_FLAG);
    end
  endfunction

  function automatic answer_t predict_cmd(logic [ilha_pkg::OPC_W-1:0] op,
                                          logic [ilha_pkg::REQ_W-1:0] req,
                                          logic [ilha_pkg::ADDR_W-1:0] baddr);
    answer_t         ans;
    longint unsigned bp, need, c;
    bit              good;
    ans = '0;
    good = 0;
    bp = 0;
    if (op == ilha_pkg::OP_INIT) begin
      heap_break = 0;
      heap_up = 0;
      if (HEAP_BYTES >= 16) begin
        heap_break = 16;
        tag_wr(0, 0);
        tag_wr(4, 8 | ALLOC_FLAG);
        tag_wr(8, 8 | ALLOC_FLAG);
        tag_wr(12, ALLOC_FLAG);
        if (grow_heap(chunk_eff(), bp)) begin
          heap_up = 1;
          ans.ok = 1;
        end
      end
    end else if (op == ilha_pkg::OP_ALLOC) begin
      if (heap_up && req != 0) begin
        need = (req <= 8) ? ilha_pkg::MIN_BLOCK : 8 * ((longint'(req) + 15) / 8);
        if (scan_first_fit(need, bp)) good = 1;
        else begin
          c = chunk_eff();
          good = grow_heap((need > c) ? need : c, bp);
        end
        if (good) begin
          carve(bp, need);
          ans.ok = 1;
          ans.address = bp[ilha_pkg::ADDR_W-1:0];
        end
      end
    end else if (op == ilha_pkg::OP_FREE) begin
      if (heap_up) begin
        write_tags(baddr, size_at(baddr), 0);
        void'(coalesce(baddr));
        ans.ok = 1;
      end
    end
    return ans;
  endfunction

  assign answers_owed = owed_answers.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      heap_break = 0;
      heap_up = 0;
      chunk_reg = ilha_pkg::CHUNK_RESET;
      fail_count = 0;
      owed_answers.delete();
    end else begin
      // Compare first so that a command issued in the done cycle queues behind it.
      if (done) begin
        if (owed_answers.size() == 0) begin
          $error("result with no command outstanding: address %0h ok %0b", address, ok);
          fail_count++;
        end else begin
          want = owed_answers.pop_front();
          if (address !== want.address) begin
            $error("address: expected %0h actual %0h", want.address, address);
            fail_count++;
          end
          if (ok !== want.ok) begin
            $error("ok: expected %0b actual %0b", want.ok, ok);
            fail_count++;
          end
        end
      end
      // A register transfer lands before any command taken at the same edge.
      if (cfg_valid && cfg_ready) chunk_reg = chunk_bytes;
      if (start && !busy) begin
        owed_answers.push_back(predict_cmd(opcode, request_bytes, block_address));
      end
    end
  end

endmodule

[sim/implicit_list_heap_allocator_tb.sv]
`timescale 1ns / 1ps

module implicit_list_heap_allocator_tb;

  // The stall limit leaves a wide margin above the slowest correct command,
  // a scan over a heap full of minimum blocks.
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 1500;
  // An opcode the block does not define.
  localparam logic [ilha_pkg::OPC_W-1:0] OP_UNKNOWN = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [ilha_pkg::OPC_W-1:0]    opcode;
  logic [ilha_pkg::REQ_W-1:0]    request_bytes;
  logic [ilha_pkg::ADDR_W-1:0]   block_address;
  logic                          done;
  logic [ilha_pkg::ADDR_W-1:0]   address;
  logic                          ok;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ilha_pkg::CHUNK_W-1:0]  chunk_bytes;
  int                            fail_count;
  int                            answers_owed;

  // Stimulus bookkeeping: payload offsets that are currently allocated, so
  // frees only ever name real blocks while the heap is up.
  logic [ilha_pkg::ADDR_W-1:0]   live_blocks [$];
  bit                            heap_up;
  bit                            allow_gaps;
  int                            cmd_count, alloc_hits, free_count, init_count, cfg_count;
  int                            stall_cycles;

  implicit_list_heap_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .request_bytes(request_bytes), .block_address(block_address), .done(done),
    .address(address), .ok(ok), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .chunk_bytes(chunk_bytes)
  );

  implicit_list_heap_allocator_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .request_bytes(request_bytes), .block_address(block_address), .done(done),
    .address(address), .ok(ok), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .chunk_bytes(chunk_bytes), .fail_count(fail_count), .answers_owed(answers_owed)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which no command and no answer is transferred.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("implicit_list_heap_allocator_tb NOT OK");
        $finish;
      end
    end
  end

  // A random pause before roughly six transfers in a hundred.
  task automatic maybe_pause();
    if (allow_gaps && $urandom_range(99) < 6) repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  // Writes the chunk register; only called while no command is in flight.
  task automatic set_chunk(logic [ilha_pkg::CHUNK_W-1:0] val);
    maybe_pause();
    cfg_valid <= 1;
    chunk_bytes <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    chunk_bytes <= ilha_pkg::CHUNK_W'($urandom);
    cfg_count++;
  endtask

  // Issues one command and waits for its answer, then updates the list of
  // live blocks from what came back.
  task automatic run_cmd(logic [ilha_pkg::OPC_W-1:0] op, logic [ilha_pkg::REQ_W-1:0] req,
                         logic [ilha_pkg::ADDR_W-1:0] baddr);
    maybe_pause();
    start <= 1;
    opcode <= op;
    request_bytes <= req;
    block_address <= baddr;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 0;
    opcode <= ilha_pkg::OPC_W'($urandom);
    request_bytes <= ilha_pkg::REQ_W'($urandom);
    block_address <= ilha_pkg::ADDR_W'($urandom);
    @(posedge clk);
    while (!done) @(posedge clk);
    cmd_count++;
    if (op == ilha_pkg::OP_INIT) begin
      init_count++;
      heap_up = ok;
      live_blocks.delete();
    end else if (op == ilha_pkg::OP_ALLOC && ok) begin
      alloc_hits++;
      live_blocks.push_back(address);
    end else if (op == ilha_pkg::OP_FREE) begin
      free_count++;
    end
    @(negedge clk);
  endtask

  // Frees a randomly chosen live block.
  task automatic free_some();
    int idx;
    logic [ilha_pkg::ADDR_W-1:0] bp;
    idx = $urandom_range(live_blocks.size() - 1);
    bp = live_blocks[idx];
    live_blocks.delete(idx);
    run_cmd(ilha_pkg::OP_FREE, ilha_pkg::REQ_W'($urandom), bp);
  endtask

  // Request sizes lean small so the heap fills with many blocks; a few are
  // large enough to force an extension or to fail outright.
  function automatic logic [ilha_pkg::REQ_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 80) return ilha_pkg::REQ_W'($urandom_range(1, 200));
    if (r < 97) return ilha_pkg::REQ_W'($urandom_range(201, 6000));
    return ilha_pkg::REQ_W'($urandom_range(6001, 65535));
  endfunction

  initial begin
    logic [ilha_pkg::CHUNK_W-1:0] chunk_menu [8];
    int r, phase;
    rst = 1;
    start = 0;
    opcode = ilha_pkg::OP_INIT;
    request_bytes = 0;
    block_address = 0;
    cfg_valid = 0;
    chunk_bytes = 0;
    heap_up = 0;
    allow_gaps = 1;
    cmd_count = 0;
    alloc_hits = 0;
    free_count = 0;
    init_count = 0;
    cfg_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part. Before any init, allocate and free must fail, and so
    // must an opcode the block does not know.
    run_cmd(ilha_pkg::OP_ALLOC, 16'd64, 16'h0000);
    run_cmd(ilha_pkg::OP_FREE, 16'h0000, 16'hFFFF);
    run_cmd(OP_UNKNOWN, 16'hFFFF, 16'hFFFF);
    // Init with the reset chunk size, then the edge request sizes.
    run_cmd(ilha_pkg::OP_INIT, 16'hFFFF, 16'hFFFF);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd0, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd1, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd8, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd9, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd4000, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'hFFFF, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd30000, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd30000, 16'h0000);
    run_cmd(OP_UNKNOWN, 16'h0000, 16'h0000);
    // Freeing the live blocks in random order exercises the merge cases.
    while (live_blocks.size() > 0) free_some();
    run_cmd(ilha_pkg::OP_ALLOC, 16'd24, 16'h0000);
    // A repeated init rebuilds the heap from scratch.
    run_cmd(ilha_pkg::OP_INIT, 16'h0000, 16'h0000);
    // A chunk that cannot fit leaves the heap down; an odd one is rounded.
    set_chunk(17'h1FFFF);
    run_cmd(ilha_pkg::OP_INIT, 16'h0000, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd100, 16'h0000);
    run_cmd(ilha_pkg::OP_FREE, 16'd0, 16'h8000);
    set_chunk(17'd9);
    run_cmd(ilha_pkg::OP_INIT, 16'h0000, 16'h0000);
    run_cmd(ilha_pkg::OP_ALLOC, 16'd40, 16'h0000);

    // Random part in phases, each with its own chunk size and a fresh init.
    chunk_menu = '{17'd16, 17'd4096, 17'd0, 17'd65536, 17'd1, 17'd65520, 17'd200, 17'd1024};
    phase = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      allow_gaps = !(i >= 500 && i < 800);
      if (i % 150 == 0) begin
        if (phase < 8) set_chunk(chunk_menu[phase]);
        else set_chunk(ilha_pkg::CHUNK_W'($urandom_range(16, 70000)));
        phase++;
        run_cmd(ilha_pkg::OP_INIT, ilha_pkg::REQ_W'($urandom), ilha_pkg::ADDR_W'($urandom));
      end
      r = $urandom_range(99);
      if (r < 2) begin
        run_cmd(ilha_pkg::OP_INIT, ilha_pkg::REQ_W'($urandom), ilha_pkg::ADDR_W'($urandom));
      end else if (r < 5) begin
        run_cmd(OP_UNKNOWN, ilha_pkg::REQ_W'($urandom), ilha_pkg::ADDR_W'($urandom));
      end else if (r < 7) begin
        run_cmd(ilha_pkg::OP_ALLOC, 16'd0, ilha_pkg::ADDR_W'($urandom));
      end else if (!heap_up) begin
        // Nothing reaches the store here, so any address is fair game.
        run_cmd((r & 1) ? ilha_pkg::OP_ALLOC : ilha_pkg::OP_FREE,
                ilha_pkg::REQ_W'($urandom), ilha_pkg::ADDR_W'($urandom));
      end else if (r < 55 || live_blocks.size() == 0) begin
        run_cmd(ilha_pkg::OP_ALLOC, pick_size(), ilha_pkg::ADDR_W'($urandom));
      end else begin
        free_some();
      end
    end

    // Every command waits for its answer, so only a short drain is left.
    repeat (50) @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d commands: %0d inits, %0d successful allocations, %0d frees.",
             cmd_count, init_count, alloc_hits, free_count);
    $display("Chunk register written %0d times, from the floor up to beyond the heap.",
             cfg_count);
    if (fail_count == 0) begin
      $display("implicit_list_heap_allocator_tb OK");
    end else begin
      $display("implicit_list_heap_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
